// ===== sv/tcpf_pkg.sv =====
// Shared types and constants for the touch closest-pair filter.
`default_nettype none

package tcpf_pkg;

  // Default converter sample width.
  localparam int SAMPLE_BITS_DEF = 12;

  // Sample counter within one nine-sample sequence.
  localparam int IDX_W = 4;
  localparam logic [IDX_W-1:0] IDX_FIRST    = 4'd0;
  localparam logic [IDX_W-1:0] IDX_G0_END   = 4'd2;
  localparam logic [IDX_W-1:0] IDX_G1_END   = 4'd5;
  localparam logic [IDX_W-1:0] IDX_LAST     = 4'd8;

  // Per-item control handed from the sequencer to each axis datapath.
  typedef struct packed {
    logic step;      // a touch sample is processed this cycle
    logic abort;     // pen lifted: clear every accumulator
    logic close;     // this sample ends a group of three
    logic wr0;       // store the new mean as group 0
    logic wr1;       // store the new mean as group 1
    logic last_grp;  // this sample ends the third group
  } ctl_t;

endpackage

`default_nettype wire

// ===== sv/touch_closest_pair_filter.sv =====
// Top level: input register, sample sequencer, two axis datapaths, result register.
// An item that yields a result passes through the input register and then the result register.
// Throughput: one item per cycle while the result register is free or draining; accumulate and pick are combinational.
// Only the pen-up item and the ninth sample of a sequence produce a result.
// Reset (asynchronous, active low) clears the sequence counter, sums and means.
// No clearing pass: the block accepts items in the first cycle after reset.
`default_nettype none

module touch_closest_pair_filter #(
  parameter int SAMPLE_BITS = tcpf_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // x_sample, y_sample from bit 0 up, zero filled to whole bytes
  input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata_i,
  // pen_up
  input  wire logic                                  s_axis_tuser_i,
  input  wire logic                                  s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  // x_pos, y_pos from bit 0 up, zero filled to whole bytes
  output logic      [((2*SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata_o,
  // touched
  output logic                                       m_axis_tuser_o,
  output logic                                       m_axis_tvalid_o,
  input  wire logic                                  m_axis_tready_i
);
  import tcpf_pkg::*;

  localparam int DATA_W = ((2*SAMPLE_BITS+7)/8)*8;

  logic                   in_valid_q, in_valid_d;
  logic [SAMPLE_BITS-1:0] in_x_q, in_y_q;
  logic                   in_pen_q;
  logic                   advance;
  logic [IDX_W-1:0]       idx_q, idx_d;
  ctl_t                   ctl;
  logic [SAMPLE_BITS-1:0] x_pos, y_pos;
  logic                   out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic                   out_touch_q, out_touch_d;

  // The held item moves on whenever the result register is free or draining.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  // Input register.
  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_x_q   <= s_axis_tdata_i[SAMPLE_BITS-1:0];
      in_y_q   <= s_axis_tdata_i[2*SAMPLE_BITS-1:SAMPLE_BITS];
      in_pen_q <= s_axis_tuser_i;
    end
  end

  // Sequencer control for the held item.
  always_comb begin
    ctl.step     = advance && !in_pen_q;
    ctl.abort    = advance && in_pen_q;
    ctl.wr0      = (idx_q == IDX_G0_END);
    ctl.wr1      = (idx_q == IDX_G1_END);
    ctl.last_grp = (idx_q == IDX_LAST);
    ctl.close    = ctl.wr0 || ctl.wr1 || ctl.last_grp;
  end

  // Sample counter within the sequence.
  always_comb begin
    idx_d = idx_q;
    if (ctl.abort) begin
      idx_d = IDX_FIRST;
    end else if (ctl.step) begin
      idx_d = ctl.last_grp ? IDX_FIRST : idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= IDX_FIRST;
    end else begin
      idx_q <= idx_d;
    end
  end

  tcpf_axis #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_axis_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .sample_i(in_x_q),
    .pos_o   (x_pos)
  );

  tcpf_axis #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_axis_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .sample_i(in_y_q),
    .pos_o   (y_pos)
  );

  // Result register: updated on every advance, valid only for a pen-up item or the ninth sample.
  always_comb begin
    out_valid_d = out_valid_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_touch_d = out_touch_q;
    if (advance) begin
      out_valid_d = in_pen_q || ctl.last_grp;
      out_touch_d = !in_pen_q;
      out_x_d     = in_pen_q ? '0 : x_pos;
      out_y_d     = in_pen_q ? '0 : y_pos;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_touch_q <= out_touch_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_touch_q;
  assign m_axis_tdata_o  = DATA_W'({out_y_q, out_x_q});

  // The counter never leaves the nine-sample range.
  assert property (@(posedge clk_i) disable iff (!rst_ni) idx_q <= IDX_LAST)
    else $error("sample counter out of range");

  // A pen-up result carries a zero position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("pen-up result with nonzero position");

  // A pen-up item yields an untouched result and restarts the sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.abort |=> m_axis_tvalid_o && !m_axis_tuser_o && idx_q == IDX_FIRST)
    else $error("pen-up item not handled");

  // The ninth sample yields a touched result and restarts the sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.step && ctl.last_grp |=> m_axis_tvalid_o && m_axis_tuser_o && idx_q == IDX_FIRST)
    else $error("final sample did not produce a position");

  // Samples before the ninth produce no result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.step && !ctl.last_grp |=> !m_axis_tvalid_o)
    else $error("unexpected result for an intermediate sample");

endmodule

`default_nettype wire

// ===== sv/tcpf_pick.sv =====
// Closest-pair selection of three group means and their truncated average.
`default_nettype none

module tcpf_pick #(
  parameter int SAMPLE_BITS = tcpf_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic [SAMPLE_BITS-1:0] m0_i,
  input  wire logic [SAMPLE_BITS-1:0] m1_i,
  input  wire logic [SAMPLE_BITS-1:0] m2_i,
  output logic      [SAMPLE_BITS-1:0] avg_o
);
  import tcpf_pkg::*;

  logic [SAMPLE_BITS-1:0] d01, d12, d02;
  logic [SAMPLE_BITS:0]   s01, s12, s02, sum;

  // Absolute differences and pair sums.
  always_comb begin
    d01 = (m0_i > m1_i) ? m0_i - m1_i : m1_i - m0_i;
    d12 = (m1_i > m2_i) ? m1_i - m2_i : m2_i - m1_i;
    d02 = (m0_i > m2_i) ? m0_i - m2_i : m2_i - m0_i;
    s01 = {1'b0, m0_i} + {1'b0, m1_i};
    s12 = {1'b0, m1_i} + {1'b0, m2_i};
    s02 = {1'b0, m0_i} + {1'b0, m2_i};
  end

  // Pick the pair; the outer pair (0,2) wins every tie it is in, and a tie of the other two goes to pair (1,2).
  always_comb begin
    if (d01 < d12) begin
      sum = (d01 < d02) ? s01 : s02;
    end else begin
      sum = (d12 < d02) ? s12 : s02;
    end
  end

  assign avg_o = sum[SAMPLE_BITS:1];

endmodule

`default_nettype wire

// ===== sv/tcpf_axis.sv =====
// One axis: group accumulator, divide by three, stored means and pair pick.
`default_nettype none

module tcpf_axis #(
  parameter int SAMPLE_BITS = tcpf_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire tcpf_pkg::ctl_t         ctl_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  output logic      [SAMPLE_BITS-1:0] pos_o
);
  import tcpf_pkg::*;

  localparam int SUM_W  = SAMPLE_BITS + 2;
  localparam int DIV_K  = SUM_W + 2;
  localparam int DIV_M  = (2**DIV_K + 2) / 3;
  localparam int PROD_W = SUM_W + DIV_K;

  logic [SUM_W-1:0]       sum_q, sum_d, sum_new;
  logic [SAMPLE_BITS-1:0] mean0_q, mean0_d, mean1_q, mean1_d, mean_new;
  logic [PROD_W-1:0]      prod;

  // Running sum including this sample, and its mean by reciprocal multiply.
  always_comb begin
    sum_new  = sum_q + SUM_W'(sample_i);
    prod     = PROD_W'(sum_new) * PROD_W'(DIV_K'(DIV_M));
    mean_new = prod[DIV_K +: SAMPLE_BITS];
  end

  // Accumulator and mean updates.
  always_comb begin
    sum_d   = sum_q;
    mean0_d = mean0_q;
    mean1_d = mean1_q;
    if (ctl_i.abort) begin
      sum_d   = '0;
      mean0_d = '0;
      mean1_d = '0;
    end else if (ctl_i.step) begin
      if (ctl_i.close) begin
        sum_d = '0;
        if (ctl_i.wr0) begin
          mean0_d = mean_new;
        end
        if (ctl_i.wr1) begin
          mean1_d = mean_new;
        end
        if (ctl_i.last_grp) begin
          mean0_d = '0;
          mean1_d = '0;
        end
      end else begin
        sum_d = sum_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      mean0_q <= '0;
      mean1_q <= '0;
    end else begin
      sum_q   <= sum_d;
      mean0_q <= mean0_d;
      mean1_q <= mean1_d;
    end
  end

  // Final selection over the two stored means and the third one just formed.
  tcpf_pick #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_pick (
    .m0_i (mean0_q),
    .m1_i (mean1_q),
    .m2_i (mean_new),
    .avg_o(pos_o)
  );

endmodule

`default_nettype wire
